[rtl/mer_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked event ring package
// Widths, codes and control bundles shared by the event ring modules.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int QUEUE_DEPTH = 512;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);

    localparam int ACTION_W  = 2;
    localparam int CAT_W     = 32;
    localparam int KIND_W    = 8;
    localparam int PAYLOAD_W = 64;
    localparam int TIME_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int PERIOD_W  = 10;
    localparam int TICK_W    = 10;
    localparam int FRAC_W    = 16;

    // delta never exceeds period * 1000 < 2^20
    localparam int DELTA_W    = 20;
    localparam int TICK_LIMIT = 1000;
    localparam int DIV_STEPS  = TICK_W + FRAC_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TCAT   = 2'd2;

    localparam logic [CAT_W-1:0]    RST_MASK   = 32'd0;
    localparam logic [PERIOD_W-1:0] RST_PERIOD = 10'd25;
    localparam logic [CAT_W-1:0]    RST_TCAT   = 32'd1;

    localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TIME = 2'd2;

    localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MASKED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOTIMER   = 3'd5;

    typedef struct packed {
        logic [CAT_W-1:0]     category;
        logic [KIND_W-1:0]    kind;
        logic [PAYLOAD_W-1:0] payload;
        logic [TIME_W-1:0]    stamp;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic capture;
        logic prep;
        logic div_step;
        logic mul;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

[rtl/mer_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event ring request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface mer_in_if;
    import mer_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [CAT_W-1:0]     event_category;
    logic [KIND_W-1:0]    event_kind;
    logic [PAYLOAD_W-1:0] event_payload;
    logic [TIME_W-1:0]    time_now;

    modport source (
        output valid, action, event_category, event_kind, event_payload, time_now,
        input  ready
    );

    modport sink (
        input  valid, action, event_category, event_kind, event_payload, time_now,
        output ready
    );

endinterface

[rtl/mer_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event ring response channel
// Valid/ready channel carrying one response item.
// ----------------------------------------------------------------------------
interface mer_out_if;
    import mer_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [CAT_W-1:0]     out_category;
    logic [KIND_W-1:0]    out_kind;
    logic [PAYLOAD_W-1:0] out_payload;
    logic [TIME_W-1:0]    out_stamp;
    logic [TICK_W-1:0]    tick_count;
    logic [FRAC_W-1:0]    tick_fraction;

    modport source (
        output valid, status, out_category, out_kind, out_payload, out_stamp,
               tick_count, tick_fraction,
        input  ready
    );

    modport sink (
        input  valid, status, out_category, out_kind, out_payload, out_stamp,
               tick_count, tick_fraction,
        output ready
    );

endinterface

[rtl/mer_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mer_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mer_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event ring controller
// Sequences request capture, tick division and the final commit.
// ----------------------------------------------------------------------------
module mer_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [mer_pkg::ACTION_W-1:0]  i_in_action,
    output logic                          o_in_ready,
    output mer_pkg::t_cmd                 o_cmd,
    input  mer_pkg::t_sts                 i_sts
);
    import mer_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_PREP = 5'b00100,
        S_DIV  = 5'b01000,
        S_MUL  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 w_in_fire;
    logic                 w_div_last;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_div_last = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = w_in_fire;
        o_cmd.prep     = (r_state == S_PREP);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.commit   = (r_state == S_EXEC) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = (i_in_action == ACT_TIME) ? S_PREP : S_EXEC;
                end
            end
            S_PREP: begin
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (w_div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

[rtl/mer_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event ring datapath
// Ring storage, indexes, tick base, radix-2 tick divider and result register.
// ----------------------------------------------------------------------------
module mer_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mer_pkg::t_cmd                  i_cmd,
    output mer_pkg::t_sts                  o_sts,
    input  logic                           i_cfg_we,
    input  logic [mer_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mer_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [mer_pkg::ACTION_W-1:0]   i_action,
    input  logic [mer_pkg::CAT_W-1:0]      i_event_category,
    input  logic [mer_pkg::KIND_W-1:0]     i_event_kind,
    input  logic [mer_pkg::PAYLOAD_W-1:0]  i_event_payload,
    input  logic [mer_pkg::TIME_W-1:0]     i_time_now,
    mer_out_if.source                      o_out
);
    import mer_pkg::*;

    // configuration
    logic [CAT_W-1:0]    r_mask;
    logic [PERIOD_W-1:0] r_period;
    logic [CAT_W-1:0]    r_tcat;
    logic [DELTA_W-1:0]  r_limit;
    logic [PERIOD_W-1:0] w_period;

    // ring state
    logic [ADDR_W-1:0] r_rd_idx, r_wr_idx;
    logic [TIME_W-1:0] r_base;

    // captured request
    logic [ACTION_W-1:0]  r_action;
    logic [CAT_W-1:0]     r_cat;
    logic [KIND_W-1:0]    r_kind;
    logic [PAYLOAD_W-1:0] r_pay;
    logic [TIME_W-1:0]    r_now;

    // divider and tick product
    logic [PERIOD_W-1:0]  r_rem;
    logic [DIV_STEPS-1:0] r_q;
    logic [DELTA_W-1:0]   r_prod;

    // result register
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_out_status;
    logic [CAT_W-1:0]     r_out_cat;
    logic [KIND_W-1:0]    r_out_kind;
    logic [PAYLOAD_W-1:0] r_out_pay;
    logic [TIME_W-1:0]    r_out_stamp;
    logic [TICK_W-1:0]    r_out_ticks;
    logic [FRAC_W-1:0]    r_out_frac;

    logic [TIME_W-1:0]   w_delta_full;
    logic                w_rebase;
    logic [DELTA_W-1:0]  n_delta;
    logic [PERIOD_W:0]   w_trial;
    logic [PERIOD_W:0]   w_diff;
    logic                w_ge;
    logic [TICK_W-1:0]   w_ticks;
    logic [FRAC_W-1:0]   w_frac;
    logic [TIME_W-1:0]   w_tbase;
    logic                w_time_push;
    logic                w_push;
    t_slot               w_wslot;
    t_slot               w_rslot;
    logic                w_masked;
    logic [ADDR_W-1:0]   w_wr_next;
    logic [ADDR_W-1:0]   w_rd_next;
    logic                w_full;
    logic                w_empty;
    logic                w_store;
    logic                w_deliver;
    logic [STATUS_W-1:0] w_status;

    assign w_period = (r_period == '0) ? PERIOD_W'(1) : r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= RST_MASK;
            r_period <= RST_PERIOD;
            r_tcat   <= RST_TCAT;
            r_limit  <= DELTA_W'(int'(RST_PERIOD) * TICK_LIMIT);
        end else begin
            r_limit <= {{(DELTA_W-PERIOD_W){1'b0}}, w_period} * DELTA_W'(TICK_LIMIT);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MASK:   r_mask   <= i_cfg_data[CAT_W-1:0];
                    CFG_PERIOD: r_period <= i_cfg_data[PERIOD_W-1:0];
                    CFG_TCAT:   r_tcat   <= i_cfg_data[CAT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // elapsed time since the tick base, rebased when stale or out of range
    assign w_delta_full = r_now - r_base;
    assign w_rebase     = (r_base == '0) || (w_delta_full == '0)
                       || (w_delta_full > {{(TIME_W-DELTA_W){1'b0}}, r_limit});
    assign n_delta      = w_rebase ? DELTA_W'(1) : w_delta_full[DELTA_W-1:0];

    // restoring division of (delta << 16) by period, one quotient bit a cycle
    assign w_trial = {r_rem, r_q[DIV_STEPS-1]};
    assign w_ge    = (w_trial >= {1'b0, w_period});
    assign w_diff  = w_trial - {1'b0, w_period};
    assign w_ticks = r_q[DIV_STEPS-1:FRAC_W];
    assign w_frac  = r_q[FRAC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_cat    <= i_event_category;
            r_kind   <= i_event_kind;
            r_pay    <= i_event_payload;
            r_now    <= i_time_now;
        end
        if (i_cmd.prep) begin
            r_rem <= n_delta[DELTA_W-1:TICK_W];
            r_q   <= {n_delta[TICK_W-1:0], FRAC_W'(0)};
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[PERIOD_W-1:0] : w_trial[PERIOD_W-1:0];
            r_q   <= {r_q[DIV_STEPS-2:0], w_ge};
        end
        if (i_cmd.mul) begin
            r_prod <= {{(DELTA_W-TICK_W){1'b0}}, w_ticks}
                    * {{(DELTA_W-PERIOD_W){1'b0}}, w_period};
        end
    end

    // push path shared by client pushes and timer events
    assign w_tbase     = r_base + {{(TIME_W-DELTA_W){1'b0}}, r_prod};
    assign w_time_push = (r_action == ACT_TIME) && (w_ticks != '0);
    assign w_push      = (r_action == ACT_PUSH) || w_time_push;

    always_comb begin
        if (w_time_push) begin
            w_wslot.category = r_tcat;
            w_wslot.kind     = '0;
            w_wslot.payload  = {{(PAYLOAD_W-TICK_W){1'b0}}, w_ticks};
            w_wslot.stamp    = w_tbase;
        end else begin
            w_wslot.category = r_cat;
            w_wslot.kind     = r_kind;
            w_wslot.payload  = r_pay;
            w_wslot.stamp    = r_base;
        end
    end

    assign w_wr_next = (r_wr_idx == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
    assign w_rd_next = (r_rd_idx == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_idx + 1'b1;
    assign w_masked  = |(w_wslot.category & r_mask);
    assign w_full    = (w_wr_next == r_rd_idx);
    assign w_empty   = (r_rd_idx == r_wr_idx);
    assign w_store   = w_push && !w_masked && !w_full;
    assign w_deliver = (r_action == ACT_POP) && !w_empty;

    always_comb begin
        if (w_push) begin
            w_status = w_masked ? ST_MASKED : (w_full ? ST_FULL : ST_STORED);
        end else if (r_action == ACT_POP) begin
            w_status = w_empty ? ST_EMPTY : ST_DELIVERED;
        end else begin
            w_status = ST_NOTIMER;
        end
    end

    // read port follows the read index so the head slot is ready for a pop
    mer_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && w_store),
        .i_waddr (r_wr_idx),
        .i_wdata (w_wslot),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rslot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.prep && w_rebase) begin
                r_base <= r_now;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                if (w_store) begin
                    r_wr_idx <= w_wr_next;
                end
                if (w_deliver) begin
                    r_rd_idx <= w_rd_next;
                end
                if (w_time_push) begin
                    r_base <= w_tbase;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= w_status;
            r_out_cat    <= w_deliver ? w_rslot.category : '0;
            r_out_kind   <= w_deliver ? w_rslot.kind     : '0;
            r_out_pay    <= w_deliver ? w_rslot.payload  : '0;
            r_out_stamp  <= w_deliver ? w_rslot.stamp    : '0;
            r_out_ticks  <= (r_action == ACT_TIME) ? w_ticks : '0;
            r_out_frac   <= (r_action == ACT_TIME) ? w_frac  : '0;
        end
    end

    assign o_sts.out_free = !r_out_valid || o_out.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.out_category  = r_out_cat;
    assign o_out.out_kind      = r_out_kind;
    assign o_out.out_payload   = r_out_pay;
    assign o_out.out_stamp     = r_out_stamp;
    assign o_out.tick_count    = r_out_ticks;
    assign o_out.tick_fraction = r_out_frac;

endmodule

[rtl/masked_event_ring_with_ticker_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked event ring with millisecond ticker
// Event FIFO with a category filter and a tick base that emits timer events.
// ----------------------------------------------------------------------------
// Requests enter on i_in (valid/ready): push an event, pop the oldest event,
// or a time update carrying the millisecond clock. Every request yields exactly
// one response on o_out (valid/ready) with a status code and, for a pop or a
// time update, the event fields or the whole and fractional tick counts.
// Push and pop go through capture, then ring memory access and commit; the
// head slot is read ahead from the memory's registered read port. A time
// update goes through capture, delta, the 26-step radix-2 divider that yields
// ticks and the Q0.16 fraction together, multiply and commit. One request is
// in work at a time. The response register decouples the sides: a new
// request is taken while a response waits; if the receiver stalls, the next
// commit holds until the response is taken. Reset empties the ring, clears
// the tick base and loads the register defaults; it needs no clearing pass.
// Configuration writes on i_cfg_* take effect at once; the user must make
// them while no request is in work, which the block does not enforce.
// ----------------------------------------------------------------------------
module masked_event_ring_with_ticker_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mer_in_if.sink                         i_in,
    mer_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [mer_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mer_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mer_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_in.ready = w_in_ready;

    mer_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .o_in_ready  (w_in_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    mer_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_in.action),
        .i_event_category (i_in.event_category),
        .i_event_kind     (i_in.event_kind),
        .i_event_payload  (i_in.event_payload),
        .i_time_now       (i_in.time_now),
        .o_out            (o_out)
    );

endmodule
